>>> src/mss_pkg.sv
package mss_pkg;

	// Table geometry
	localparam int NumPat   = 40;
	localparam int NumLead  = 18;
	localparam int PatBytes = 14;
	localparam int PatIdxW  = $clog2(PatBytes);
	localparam int LenW     = 6;
	localparam int TypeW    = 5;

	typedef logic [7:0]       byte_t;
	typedef logic [LenW-1:0]  len_t;
	typedef logic [TypeW-1:0] type_t;
	typedef byte_t            row_t [PatBytes];

	// Content type codes used outside the table
	localparam type_t TypePlain = 5'd4;
	localparam type_t TypeOctet = 5'd20;

	// Byte codes
	localparam byte_t ChTab   = 8'h09;
	localparam byte_t ChLf    = 8'h0A;
	localparam byte_t ChCr    = 8'h0D;
	localparam byte_t ChSpace = 8'h20;
	localparam byte_t ChGt    = 8'h3E;

	// Per-pattern compare flags from the pattern bank
	typedef struct packed {
		logic [NumPat-1:0] active;
		logic [NumPat-1:0] byte_ok;
		logic [NumPat-1:0] at_end;
	} cmp_t;

	localparam len_t SigLen [NumPat] = '{
		6'd14, 6'd5, 6'd5, 6'd7, 6'd7, 6'd3, 6'd4, 6'd5, 6'd6, 6'd2,
		6'd6,  6'd6, 6'd2, 6'd5, 6'd3, 6'd2, 6'd4, 6'd5, 6'd5, 6'd11,
		6'd4,  6'd4, 6'd4, 6'd4, 6'd4, 6'd2, 6'd6, 6'd6, 6'd14, 6'd8,
		6'd3,  6'd3, 6'd4, 6'd7, 6'd36, 6'd4, 6'd4, 6'd4, 6'd4, 6'd4
	};

	// Only the embedded-font signature starts away from byte 0
	localparam len_t SigSkip [NumPat] = '{34: 6'd34, default: 6'd0};

	localparam type_t SigType [NumPat] = '{
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd1,  5'd2,  5'd3,
		5'd4,  5'd4,  5'd4,  5'd5,  5'd5,  5'd6,  5'd7,  5'd7,  5'd8,  5'd9,
		5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
	};

	localparam row_t SigPat [NumPat] = '{
		'{8'h3C, 8'h21, 8'h44, 8'h4F, 8'h43, 8'h54, 8'h59, 8'h50, 8'h45, 8'h20,
		  8'h48, 8'h54, 8'h4D, 8'h4C},
		'{0: 8'h3C, 1: 8'h48, 2: 8'h54, 3: 8'h4D, 4: 8'h4C, default: 8'h00},
		'{0: 8'h3C, 1: 8'h48, 2: 8'h45, 3: 8'h41, 4: 8'h44, default: 8'h00},
		'{0: 8'h3C, 1: 8'h53, 2: 8'h43, 3: 8'h52, 4: 8'h49, 5: 8'h50, 6: 8'h54,
		  default: 8'h00},
		'{0: 8'h3C, 1: 8'h49, 2: 8'h46, 3: 8'h52, 4: 8'h41, 5: 8'h4D, 6: 8'h45,
		  default: 8'h00},
		'{0: 8'h3C, 1: 8'h48, 2: 8'h31, default: 8'h00},
		'{0: 8'h3C, 1: 8'h44, 2: 8'h49, 3: 8'h56, default: 8'h00},
		'{0: 8'h3C, 1: 8'h46, 2: 8'h4F, 3: 8'h4E, 4: 8'h54, default: 8'h00},
		'{0: 8'h3C, 1: 8'h54, 2: 8'h41, 3: 8'h42, 4: 8'h4C, 5: 8'h45, default: 8'h00},
		'{0: 8'h3C, 1: 8'h41, default: 8'h00},
		'{0: 8'h3C, 1: 8'h53, 2: 8'h54, 3: 8'h59, 4: 8'h4C, 5: 8'h45, default: 8'h00},
		'{0: 8'h3C, 1: 8'h54, 2: 8'h49, 3: 8'h54, 4: 8'h4C, 5: 8'h45, default: 8'h00},
		'{0: 8'h3C, 1: 8'h42, default: 8'h00},
		'{0: 8'h3C, 1: 8'h42, 2: 8'h4F, 3: 8'h44, 4: 8'h59, default: 8'h00},
		'{0: 8'h3C, 1: 8'h42, 2: 8'h52, default: 8'h00},
		'{0: 8'h3C, 1: 8'h50, default: 8'h00},
		'{0: 8'h3C, 1: 8'h21, 2: 8'h2D, 3: 8'h2D, default: 8'h00},
		'{0: 8'h3C, 1: 8'h3F, 2: 8'h78, 3: 8'h6D, 4: 8'h6C, default: 8'h00},
		'{0: 8'h25, 1: 8'h50, 2: 8'h44, 3: 8'h46, 4: 8'h2D, default: 8'h00},
		'{0: 8'h25, 1: 8'h21, 2: 8'h50, 3: 8'h53, 4: 8'h2D, 5: 8'h41, 6: 8'h64,
		  7: 8'h6F, 8: 8'h62, 9: 8'h65, 10: 8'h2D, default: 8'h00},
		'{0: 8'hFE, 1: 8'hFF, default: 8'h00},
		'{0: 8'hFF, 1: 8'hFE, default: 8'h00},
		'{0: 8'hEF, 1: 8'hBB, 2: 8'hBF, default: 8'h00},
		'{0: 8'h00, 1: 8'h00, 2: 8'h01, default: 8'h00},
		'{0: 8'h00, 1: 8'h00, 2: 8'h02, default: 8'h00},
		'{0: 8'h42, 1: 8'h4D, default: 8'h00},
		'{0: 8'h47, 1: 8'h49, 2: 8'h46, 3: 8'h38, 4: 8'h37, 5: 8'h61, default: 8'h00},
		'{0: 8'h47, 1: 8'h49, 2: 8'h46, 3: 8'h38, 4: 8'h39, 5: 8'h61, default: 8'h00},
		'{0: 8'h52, 1: 8'h49, 2: 8'h46, 3: 8'h46, 8: 8'h57, 9: 8'h45, 10: 8'h42,
		  11: 8'h50, 12: 8'h56, 13: 8'h50, default: 8'h00},
		'{0: 8'h89, 1: 8'h50, 2: 8'h4E, 3: 8'h47, 4: 8'h0D, 5: 8'h0A, 6: 8'h1A,
		  7: 8'h0A, default: 8'h00},
		'{0: 8'hFF, 1: 8'hD8, 2: 8'hFF, default: 8'h00},
		'{0: 8'h1F, 1: 8'h8B, 2: 8'h08, default: 8'h00},
		'{0: 8'h50, 1: 8'h4B, 2: 8'h03, 3: 8'h04, default: 8'h00},
		'{0: 8'h52, 1: 8'h61, 2: 8'h72, 3: 8'h20, 4: 8'h1A, 5: 8'h07, default: 8'h00},
		'{0: 8'h4C, 1: 8'h50, default: 8'h00},
		'{0: 8'h00, 1: 8'h01, default: 8'h00},
		'{0: 8'h4F, 1: 8'h54, 2: 8'h54, 3: 8'h4F, default: 8'h00},
		'{0: 8'h74, 1: 8'h74, 2: 8'h63, 3: 8'h66, default: 8'h00},
		'{0: 8'h77, 1: 8'h4F, 2: 8'h46, 3: 8'h46, default: 8'h00},
		'{0: 8'h77, 1: 8'h4F, 2: 8'h46, 3: 8'h32, default: 8'h00}
	};

	// Case-folding and don't-care masks; rows not listed compare every byte
	localparam row_t SigMsk [NumPat] = '{
		0:  '{8'hFF, 8'hFF, 8'hDF, 8'hDF, 8'hDF, 8'hDF, 8'hDF, 8'hDF, 8'hDF, 8'hFF,
		      8'hDF, 8'hDF, 8'hDF, 8'hDF},
		1:  '{0: 8'hFF, default: 8'hDF},
		2:  '{0: 8'hFF, default: 8'hDF},
		3:  '{0: 8'hFF, default: 8'hDF},
		4:  '{0: 8'hFF, default: 8'hDF},
		5:  '{1: 8'hDF, default: 8'hFF},
		6:  '{0: 8'hFF, default: 8'hDF},
		7:  '{0: 8'hFF, default: 8'hDF},
		8:  '{0: 8'hFF, default: 8'hDF},
		9:  '{0: 8'hFF, default: 8'hDF},
		10: '{0: 8'hFF, default: 8'hDF},
		11: '{0: 8'hFF, default: 8'hDF},
		12: '{0: 8'hFF, default: 8'hDF},
		13: '{0: 8'hFF, default: 8'hDF},
		14: '{0: 8'hFF, default: 8'hDF},
		15: '{0: 8'hFF, default: 8'hDF},
		20: '{0: 8'hFF, 1: 8'hFF, default: 8'h00},
		21: '{0: 8'hFF, 1: 8'hFF, default: 8'h00},
		22: '{0: 8'hFF, 1: 8'hFF, 2: 8'hFF, default: 8'h00},
		28: '{4: 8'h00, 5: 8'h00, 6: 8'h00, 7: 8'h00, default: 8'hFF},
		default: '{default: 8'hFF}
	};

endpackage

>>> src/mss_hdr_if.sv
interface mss_hdr_if;
	logic               valid;
	logic               ready;
	mss_pkg::byte_t     byte_value;
	logic               byte_present;
	logic               last_item;

	modport source (output valid, byte_value, byte_present, last_item, input ready);
	modport sink   (input valid, byte_value, byte_present, last_item, output ready);
endinterface

>>> src/mss_res_if.sv
interface mss_res_if;
	logic               valid;
	logic               ready;
	mss_pkg::type_t     type_code;
	logic               pattern_hit;
	logic               result_last;

	modport source (output valid, type_code, pattern_hit, result_last, input ready);
	modport sink   (input valid, type_code, pattern_hit, result_last, output ready);
endinterface

>>> src/mss_pattern_bank.sv
module mss_pattern_bank #(
	parameter int PosW = 11
) (
	input  mss_pkg::byte_t                   byte_value,
	input  logic [PosW-1:0]                  anchor_pos,
	input  logic                             anchor_en,
	input  logic [PosW-1:0]                  lead_pos,
	input  logic                             lead_en,
	input  logic [mss_pkg::NumLead-1:0]      pending,
	output mss_pkg::cmp_t                    cmp
);

	// Masked compare of one byte at offset off of pattern k
	function automatic logic byte_match(input int k, input logic [PosW-1:0] off,
			input mss_pkg::byte_t b);
		mss_pkg::len_t                     i6;
		mss_pkg::len_t                     j;
		logic [mss_pkg::PatIdxW-1:0]       ji;
		logic                              ok;
		i6 = off[mss_pkg::LenW-1:0];
		j  = i6 - mss_pkg::SigSkip[k];
		ji = j[mss_pkg::PatIdxW-1:0];
		if (i6 < mss_pkg::SigSkip[k]) begin
			ok = 1'b1;
		end else if (j < mss_pkg::LenW'(mss_pkg::PatBytes)) begin
			ok = ((b ^ mss_pkg::SigPat[k][ji]) & mss_pkg::SigMsk[k][ji]) == 8'h00;
		end else begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	// Offset reached the pattern's final byte
	function automatic logic last_byte(input int k, input logic [PosW-1:0] off);
		mss_pkg::len_t i6;
		i6 = off[mss_pkg::LenW-1:0];
		return mss_pkg::LenW'(i6 + 1'b1) == mss_pkg::SigLen[k];
	endfunction

	always_comb begin
		// Markup patterns, offset counted from the end of the leading whitespace
		for (int k = 0; k < mss_pkg::NumLead; k++) begin
			cmp.active[k]  = lead_en && !pending[k] &&
			                 (lead_pos < PosW'(mss_pkg::SigLen[k]));
			cmp.byte_ok[k] = byte_match(k, lead_pos, byte_value);
			cmp.at_end[k]  = last_byte(k, lead_pos);
		end
		// Patterns anchored at byte 0
		for (int k = mss_pkg::NumLead; k < mss_pkg::NumPat; k++) begin
			cmp.active[k]  = anchor_en && (anchor_pos < PosW'(mss_pkg::SigLen[k]));
			cmp.byte_ok[k] = byte_match(k, anchor_pos, byte_value);
			cmp.at_end[k]  = last_byte(k, anchor_pos);
		end
	end

endmodule

>>> src/mime_signature_sniffer_unit.sv
// Content-type sniffer. Header bytes enter on hdr, one per transaction; the transaction that
// carries last_item gives one result on res (type_code, pattern_hit, result_last = 1), after
// which all match state returns to its reset value. The block takes one byte every clock unless
// a stall holds it: each byte is registered, compared against all forty signatures at once and
// folded into the registered match state, and a result is registered when its last-item
// transaction leaves the input register, so a new header may start right behind it. Bytes past
// HEADER_LIMIT are ignored. A result waiting on res stalls hdr only when the next last-item
// transaction reaches it.
module mime_signature_sniffer_unit #(
	parameter int HEADER_LIMIT = 1445
) (
	input  logic          clk,
	input  logic          arst_n,
	mss_hdr_if.sink       hdr,
	mss_res_if.source     res
);

	localparam int PosW = $clog2(HEADER_LIMIT + 1);

	// Binary control bytes
	function automatic logic is_binary(input mss_pkg::byte_t b);
		return (b <= 8'h08) || (b == 8'h0B) || (b >= 8'h0E && b <= 8'h1A) ||
		       (b >= 8'h1C && b <= 8'h1F);
	endfunction

	// First matched pattern in table order decides the type
	function automatic mss_pkg::type_t pick_type(input logic [mss_pkg::NumPat-1:0] m,
			input logic bin);
		mss_pkg::type_t t;
		t = bin ? mss_pkg::TypeOctet : mss_pkg::TypePlain;
		for (int k = mss_pkg::NumPat - 1; k >= 0; k--) begin
			if (m[k]) begin
				t = mss_pkg::SigType[k];
			end
		end
		return t;
	endfunction

	// Input stage
	logic               valid_s1;
	mss_pkg::byte_t     byte_s1;
	logic               present_s1;
	logic               last_s1;

	// Match state
	logic [PosW-1:0]                  pos_q;
	logic [PosW-1:0]                  pre_q;
	logic                             lead_done_q;
	logic [mss_pkg::NumPat-1:0]       alive_q;
	logic [mss_pkg::NumPat-1:0]       match_q;
	logic [mss_pkg::NumLead-1:0]      pend_q;
	logic                             bin_q;

	// Result register
	logic               res_valid_q;
	mss_pkg::type_t     res_type_q;
	logic               res_hit_q;

	logic                             go;
	logic                             take;
	logic                             ws;
	logic                             lead_stay;
	logic                             lead_en;
	logic [PosW-1:0]                  lead_pos;
	mss_pkg::cmp_t                    cmp;
	logic [PosW-1:0]                  pos_n;
	logic [PosW-1:0]                  pre_n;
	logic                             lead_done_n;
	logic [mss_pkg::NumPat-1:0]       alive_n;
	logic [mss_pkg::NumPat-1:0]       match_n;
	logic [mss_pkg::NumLead-1:0]      pend_n;
	logic                             bin_n;

	// Handshake: stage 1 moves on unless it holds a last item and a result is blocked on res
	assign go        = valid_s1 && (!last_s1 || !res_valid_q || res.ready);
	assign hdr.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.ready && hdr.valid) begin
			byte_s1    <= hdr.byte_value;
			present_s1 <= hdr.byte_present;
			last_s1    <= hdr.last_item;
		end
	end

	// Byte qualification and leading whitespace
	assign take      = present_s1 && (pos_q < PosW'(HEADER_LIMIT));
	assign ws        = (byte_s1 == mss_pkg::ChSpace) || (byte_s1 == mss_pkg::ChTab) ||
	                   (byte_s1 == mss_pkg::ChLf) || (byte_s1 == mss_pkg::ChCr);
	assign lead_stay = !lead_done_q && ws;
	assign lead_en   = take && !lead_stay;
	assign lead_pos  = pos_q - pre_q;

	mss_pattern_bank #(
		.PosW (PosW)
	) u_bank (
		.byte_value (byte_s1),
		.anchor_pos (pos_q),
		.anchor_en  (take),
		.lead_pos   (lead_pos),
		.lead_en    (lead_en),
		.pending    (pend_q),
		.cmp        (cmp)
	);

	// Next match state
	always_comb begin
		pos_n       = pos_q;
		pre_n       = pre_q;
		lead_done_n = lead_done_q;
		bin_n       = bin_q;
		alive_n     = alive_q;
		match_n     = match_q;
		pend_n      = pend_q;
		if (take) begin
			pos_n = pos_q + 1'b1;
			bin_n = bin_q || is_binary(byte_s1);
			if (lead_stay) begin
				pre_n = pre_q + 1'b1;
			end else begin
				lead_done_n = 1'b1;
			end
		end
		for (int k = 0; k < mss_pkg::NumLead; k++) begin
			if (lead_en && pend_q[k]) begin
				if (byte_s1 == mss_pkg::ChSpace || byte_s1 == mss_pkg::ChGt) begin
					match_n[k] = 1'b1;
				end
				pend_n[k] = 1'b0;
			end else if (cmp.active[k]) begin
				alive_n[k] = alive_q[k] && cmp.byte_ok[k];
				if (cmp.at_end[k] && alive_n[k]) begin
					pend_n[k] = 1'b1;
				end
			end
		end
		for (int k = mss_pkg::NumLead; k < mss_pkg::NumPat; k++) begin
			if (cmp.active[k]) begin
				alive_n[k] = alive_q[k] && cmp.byte_ok[k];
				if (cmp.at_end[k] && alive_n[k]) begin
					match_n[k] = 1'b1;
				end
			end
		end
	end

	// State update; a last-item transaction restarts the header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			pre_q       <= '0;
			lead_done_q <= 1'b0;
			alive_q     <= '1;
			match_q     <= '0;
			pend_q      <= '0;
			bin_q       <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				pos_q       <= '0;
				pre_q       <= '0;
				lead_done_q <= 1'b0;
				alive_q     <= '1;
				match_q     <= '0;
				pend_q      <= '0;
				bin_q       <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				pre_q       <= pre_n;
				lead_done_q <= lead_done_n;
				alive_q     <= alive_n;
				match_q     <= match_n;
				pend_q      <= pend_n;
				bin_q       <= bin_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			res_type_q <= pick_type(match_n, bin_n);
			res_hit_q  <= |match_n;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.type_code   = res_type_q;
	assign res.pattern_hit = res_hit_q;
	assign res.result_last = 1'b1;

	// Checks
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosW'(HEADER_LIMIT))
		else $error("byte position ran past the header limit");

	a_prefix_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pre_q <= pos_q)
		else $error("whitespace prefix longer than header");

	a_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & match_q[mss_pkg::NumLead-1:0]) == '0)
		else $error("markup pattern both pending and matched");

	a_miss_type: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_hit_q) |->
		(res_type_q == mss_pkg::TypePlain || res_type_q == mss_pkg::TypeOctet))
		else $error("unmatched header gave a signature type");

endmodule
